FILE: design/sbo_pkg.sv
package sbo_pkg;

    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_CONFIRM = 3'd1,
        CMD_TAKE    = 3'd2,
        CMD_FAIL    = 3'd3,
        CMD_TIMEOUT = 3'd4,
        CMD_EXPIRE  = 3'd5,
        CMD_UNBLOCK = 3'd6
    } cmd_t;

    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_ACCEPTED = 3'd1;
    localparam logic [2:0] ACT_REFUSED  = 3'd2;
    localparam logic [2:0] ACT_FAILURE  = 3'd3;
    localparam logic [2:0] ACT_SEND_EXE = 3'd4;
    localparam logic [2:0] ACT_SUCCESS  = 3'd5;
    localparam logic [2:0] ACT_RELEASED = 3'd6;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_RECOVERING = 4'd1;
    localparam logic [3:0] ERR_DUPLICATE  = 4'd2;
    localparam logic [3:0] ERR_BUSY       = 4'd3;
    localparam logic [3:0] ERR_TIMEOUT    = 4'd4;
    localparam logic [3:0] ERR_MISMATCH   = 4'd5;
    localparam logic [3:0] ERR_CAUSE_BASE = 4'd6;
    localparam logic [3:0] ERR_PHASE      = 4'd10;
    localparam logic [3:0] ERR_SEL_REJ    = 4'd11;
    localparam logic [3:0] ERR_EXE_REJ    = 4'd12;

    localparam logic [5:0] COT_ACT_CON  = 6'd7;
    localparam logic [5:0] COT_BAD_TYPE = 6'd44;
    localparam logic [5:0] COT_BAD_IOA  = 6'd47;

    localparam logic [1:0] PH_SELECT  = 2'd0;
    localparam logic [1:0] PH_QUEUED  = 2'd1;
    localparam logic [1:0] PH_EXECUTE = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  device;
        logic [15:0] request_tag;
        logic [31:0] generation;
        logic [7:0]  type_id;
        logic [15:0] common_address;
        logic [23:0] object_address;
        logic [7:0]  qualifier;
        logic [31:0] command_value;
        logic [31:0] tick_time;
        logic [5:0]  cause;
        logic [1:0]  answer_flags;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  error_code;
        logic        phase_is_execute;
        logic [5:0]  result_cause;
        logic [15:0] out_request_tag;
        logic [31:0] out_generation;
        logic [7:0]  out_type_id;
        logic [15:0] out_common_address;
        logic [23:0] out_object_address;
        logic [7:0]  out_qualifier;
        logic [31:0] out_value;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EVAL = 2'd1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_t;

endpackage

FILE: design/sbo_ctrl.sv
module sbo_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output sbo_pkg::ctrl_t ctrl
);
    import sbo_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = start ? ST_EVAL : ST_IDLE;
            ST_EVAL: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy         = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: ctrl.capture = start;
            ST_EVAL:
            begin
                busy        = 1'b1;
                ctrl.commit = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end
endmodule

FILE: design/sbo_datapath.sv
module sbo_datapath #(
    parameter int DEVICES    = 16,
    parameter int TIME_WIDTH = 32,
    parameter int GEN_WIDTH  = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sbo_pkg::ctrl_t    ctrl,
    input  sbo_pkg::in_item_t in_item,
    output logic              done,
    output sbo_pkg::out_item_t out_item
);
    import sbo_pkg::*;

    localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int TW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
    localparam int GW = (GEN_WIDTH < 32) ? GEN_WIDTH : 32;

    logic [DEVICES-1:0] valid_reg;
    logic [DEVICES-1:0] blocked_reg;
    logic [15:0]   req_reg  [DEVICES];
    logic [GW-1:0] gen_reg  [DEVICES];
    logic [1:0]    ph_reg   [DEVICES];
    logic [7:0]    type_reg [DEVICES];
    logic [15:0]   ca_reg   [DEVICES];
    logic [23:0]   ioa_reg  [DEVICES];
    logic [7:0]    qual_reg [DEVICES];
    logic [31:0]   val_reg  [DEVICES];
    logic [TW-1:0] dl_reg   [DEVICES];
    logic [GW-1:0] bgen_reg [DEVICES];

    in_item_t  it_reg;
    logic      dup_reg;
    out_item_t out_reg, out_next;
    logic      done_reg;

    // tag compare across all slots happens while the item is captured
    logic dup_now;
    always_comb
    begin
        dup_now = 1'b0;
        for (int i = 0; i < DEVICES; i++)
            if (valid_reg[i] && req_reg[i] == in_item.request_tag)
                dup_now = 1'b1;
    end

    logic          in_range;
    logic [DW-1:0] d;
    logic [GW-1:0] igen;
    logic [TW-1:0] itime;
    assign in_range = ({28'd0, it_reg.device} < 32'(DEVICES));
    assign d     = DW'(it_reg.device);
    assign igen  = GW'(it_reg.generation);
    assign itime = TW'(it_reg.tick_time);

    logic          e_valid, e_blk, is_sel, reject, late, gen_ok;
    logic [1:0]    e_ph;
    assign e_valid = in_range && valid_reg[d];
    assign e_blk   = in_range && blocked_reg[d];
    assign e_ph    = ph_reg[d];
    assign is_sel  = (e_ph == PH_SELECT);
    assign reject  = (it_reg.cause >= COT_BAD_TYPE) && (it_reg.cause <= COT_BAD_IOA);
    assign late    = (itime >= dl_reg[d]);
    assign gen_ok  = e_valid && (gen_reg[d] == igen);

    logic set_entry, clr_valid, set_block, clr_block, set_queued, set_exec;
    logic [2:0] act;
    logic [3:0] err;
    logic       ph_out;
    logic [5:0] cause_out;
    logic       use_entry;

    always_comb
    begin
        set_entry = 1'b0; clr_valid = 1'b0; set_block = 1'b0; clr_block = 1'b0;
        set_queued = 1'b0; set_exec = 1'b0;
        act = ACT_NONE; err = ERR_NONE; ph_out = 1'b0; cause_out = 6'd0;
        use_entry = 1'b1;
        if (in_range)
        begin
            case (it_reg.command)
                CMD_START:
                begin
                    use_entry = 1'b0;
                    if (e_blk)         err = ERR_RECOVERING;
                    else if (dup_reg)  err = ERR_DUPLICATE;
                    else if (e_valid)  err = ERR_BUSY;
                    act = (err != ERR_NONE) ? ACT_REFUSED : ACT_ACCEPTED;
                    set_entry = (err == ERR_NONE);
                end
                CMD_UNBLOCK:
                    clr_block = e_blk && (bgen_reg[d] == igen);
                CMD_CONFIRM:
                begin
                    if (gen_ok && type_reg[d] == it_reg.type_id
                        && ca_reg[d] == it_reg.common_address
                        && ioa_reg[d] == it_reg.object_address
                        && (it_reg.cause == COT_ACT_CON || reject))
                    begin
                        cause_out = it_reg.cause;
                        if (late)
                        begin
                            set_block = 1'b1; err = ERR_TIMEOUT;
                        end
                        else if (qual_reg[d] != it_reg.qualifier
                                 || val_reg[d] != it_reg.command_value)
                            err = ERR_MISMATCH;
                        else if (reject)
                            err = ERR_CAUSE_BASE + 4'(it_reg.cause - COT_BAD_TYPE);
                        else if (it_reg.answer_flags[0] != is_sel)
                            err = ERR_PHASE;
                        else if (it_reg.answer_flags[1])
                            err = is_sel ? ERR_SEL_REJ : ERR_EXE_REJ;
                        if (err != ERR_NONE)
                        begin
                            clr_valid = 1'b1; act = ACT_FAILURE; ph_out = !is_sel;
                        end
                        else if (is_sel)
                        begin
                            set_queued = 1'b1; act = ACT_SEND_EXE;
                        end
                        else
                        begin
                            clr_valid = 1'b1; act = ACT_SUCCESS; ph_out = 1'b1;
                        end
                    end
                end
                CMD_TAKE:
                begin
                    if (gen_ok && e_ph == PH_QUEUED)
                    begin
                        ph_out = 1'b1;
                        if (late)
                        begin
                            set_block = 1'b1; clr_valid = 1'b1;
                            act = ACT_FAILURE; err = ERR_TIMEOUT;
                        end
                        else
                        begin
                            set_exec = 1'b1; act = ACT_SEND_EXE;
                        end
                    end
                end
                CMD_FAIL, CMD_TIMEOUT, CMD_EXPIRE:
                begin
                    if (gen_ok && !(it_reg.command == CMD_EXPIRE && !late))
                    begin
                        set_block = (it_reg.command != CMD_FAIL);
                        clr_valid = 1'b1;
                        act = ACT_RELEASED;
                        err = (it_reg.command == CMD_FAIL) ? ERR_NONE : ERR_TIMEOUT;
                        ph_out = !is_sel;
                    end
                end
                default: act = ACT_NONE;
            endcase
        end
    end

    always_comb
    begin
        out_next = '0;
        if (act != ACT_NONE)
        begin
            out_next.action           = act;
            out_next.error_code       = err;
            out_next.phase_is_execute = ph_out;
            out_next.result_cause     = cause_out;
            if (use_entry)
            begin
                out_next.out_request_tag    = req_reg[d];
                out_next.out_generation     = 32'(gen_reg[d]);
                out_next.out_type_id        = type_reg[d];
                out_next.out_common_address = ca_reg[d];
                out_next.out_object_address = ioa_reg[d];
                out_next.out_qualifier      = qual_reg[d];
                out_next.out_value          = val_reg[d];
            end
            else
            begin
                out_next.out_request_tag    = it_reg.request_tag;
                out_next.out_generation     = 32'(igen);
                out_next.out_type_id        = it_reg.type_id;
                out_next.out_common_address = it_reg.common_address;
                out_next.out_object_address = it_reg.object_address;
                out_next.out_qualifier      = it_reg.qualifier;
                out_next.out_value          = it_reg.command_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            blocked_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.commit;
            if (ctrl.commit)
            begin
                if (set_entry) valid_reg[d] <= 1'b1;
                if (clr_valid) valid_reg[d] <= 1'b0;
                if (set_block) blocked_reg[d] <= 1'b1;
                if (clr_block) blocked_reg[d] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            it_reg  <= in_item;
            dup_reg <= dup_now;
        end
        if (ctrl.commit)
        begin
            out_reg <= out_next;
            if (set_block) bgen_reg[d] <= gen_reg[d];
            if (set_queued) ph_reg[d] <= PH_QUEUED;
            if (set_exec) ph_reg[d] <= PH_EXECUTE;
            if (set_entry)
            begin
                req_reg[d]  <= it_reg.request_tag;
                gen_reg[d]  <= igen;
                ph_reg[d]   <= PH_SELECT;
                type_reg[d] <= it_reg.type_id;
                ca_reg[d]   <= it_reg.common_address;
                ioa_reg[d]  <= it_reg.object_address;
                qual_reg[d] <= it_reg.qualifier;
                val_reg[d]  <= it_reg.command_value;
                dl_reg[d]   <= itime;
            end
        end
    end

    assign done     = done_reg;
    assign out_item = out_reg;
endmodule

FILE: design/select_before_operate_tracker.sv
// An accepted item is captured, then its result and strobe are registered at commit.
// No new transaction is accepted while busy; busy is high for the evaluate cycle,
// in which the slot read-modify-write is done after the parallel tag compare.
// Reset clears the slot valid and block bits and the controller; no clearing pass.
// The receiver cannot stall: each result is shown for one cycle only.
module select_before_operate_tracker #(
    parameter int DEVICES    = 16,
    parameter int TIME_WIDTH = 32,
    parameter int GEN_WIDTH  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sbo_pkg::in_item_t  in_item,
    output logic               result_valid,
    output sbo_pkg::out_item_t result
);
    import sbo_pkg::*;

    ctrl_t ctrl;

    sbo_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    sbo_datapath #(
        .DEVICES    (DEVICES),
        .TIME_WIDTH (TIME_WIDTH),
        .GEN_WIDTH  (GEN_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .in_item  (in_item),
        .done     (result_valid),
        .out_item (result)
    );

    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 result_valid)
        else $error("missing result");
    a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result repeated");
    a_commit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |-> busy)
        else $error("commit while idle");
endmodule
